// File: hdl/cima_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cima_pkg
// shared codes and thermostat constants for the cooling / ice mode arbiter
// ----------------------------------------------------------------------------
package cima_pkg;

    localparam int TEMP_W  = 10;
    localparam int DELAY_W = 14;
    localparam int MODE_W  = 2;

    // make mode codes
    localparam logic [MODE_W-1:0] MODE_STOP = 2'd0;
    localparam logic [MODE_W-1:0] MODE_COLD = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ICE  = 2'd2;

    // on thresholds, tenths of a degree
    localparam logic [TEMP_W-1:0] ON_WEAK   = 10'd140;
    localparam logic [TEMP_W-1:0] ON_SAVING = 10'd100;
    localparam logic [TEMP_W-1:0] ON_NORMAL = 10'd80;

    // off thresholds, tenths of a degree
    localparam logic [TEMP_W-1:0] OFF_WEAK        = 10'd100;
    localparam logic [TEMP_W-1:0] OFF_COOL_SAVING = 10'd60;
    localparam logic [TEMP_W-1:0] OFF_COOL_NORMAL = 10'd50;
    localparam logic [TEMP_W-1:0] OFF_WARM_SAVING = 10'd70;
    localparam logic [TEMP_W-1:0] OFF_WARM_NORMAL = 10'd60;

    // off delays, ticks
    localparam logic [DELAY_W-1:0] DELAY_SHORT       = 14'd20;
    localparam logic [DELAY_W-1:0] DELAY_WARM_SAVING = 14'd9000;
    localparam logic [DELAY_W-1:0] DELAY_WARM_NORMAL = 14'd6000;

    // ambient limit, whole degrees
    localparam logic [7:0] AMBIENT_WARM = 8'd30;

    // configuration register indexes and reset
    localparam logic REG_PROTECT_TEMP = 1'b0;
    localparam logic [TEMP_W-1:0] PROTECT_TEMP_RESET = 10'd20;

    // ice flag bit positions
    localparam int ICE_ON      = 0;
    localparam int ICE_LOW     = 1;
    localparam int ICE_FULL    = 2;
    localparam int ICE_FIRST   = 3;
    localparam int ICE_SAFETY  = 4;
    localparam int ICE_FAULT   = 5;
    localparam int ICE_SERVICE = 6;

    // cold flag bit positions
    localparam int COLD_EN     = 0;
    localparam int COLD_FILLED = 1;
    localparam int COLD_FAULT  = 2;

endpackage

// File: hdl/cooling_ice_mode_arbiter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cooling_ice_mode_arbiter_unit
// qualified thermostat, cold / ice go conditions and make-mode arbiter
// ----------------------------------------------------------------------------
// One tick transfer is accepted every clock cycle while in_stall is low.
// Each tick is held in an input register; the thermostat counters, extra-ice
// bit and make mode are updated by one pass of compare and count logic as the
// tick moves into the result register, which offers the result, and a stalled
// result holds one further tick in the input register. With decision_enable
// low the state is held and both go bits read 0. The protect_temp register
// sits at byte address 0 of the APB port.
// ----------------------------------------------------------------------------
module cooling_ice_mode_arbiter_unit #(
    parameter int QUALIFY_TICKS = 20
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // tick input
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [9:0]  cold_temp,
    input  logic [7:0]  ambient_deg,
    input  logic        cold_weak,
    input  logic        sleep_active,
    input  logic        no_use_saving,
    input  logic        ice_init_active,
    input  logic [2:0]  cold_flags,
    input  logic [6:0]  ice_flags,
    input  logic        ice_standby,
    input  logic        cold_first,
    input  logic        decision_enable,
    // result output
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  make_mode,
    output logic        cool_demand,
    output logic        cold_go,
    output logic        ice_go
);

    localparam int CNT_W = $clog2(QUALIFY_TICKS + 1);
    localparam logic [CNT_W:0] QMAX = (CNT_W + 1)'(QUALIFY_TICKS);

    // configuration
    logic [cima_pkg::TEMP_W-1:0] protect_temp_reg;
    logic cfg_write;

    // input register
    logic        s1_valid_reg;
    logic [9:0]  temp_reg;
    logic [7:0]  amb_reg;
    logic        weak_reg;
    logic        sleep_reg;
    logic        nouse_reg;
    logic        init_reg;
    logic [2:0]  cf_reg;
    logic [6:0]  icf_reg;
    logic        standby_reg;
    logic        cold_pri_reg;
    logic        enable_reg;

    // state
    logic                         demand_reg, demand_next;
    logic [CNT_W-1:0]             on_count_reg, on_count_next;
    logic [cima_pkg::DELAY_W-1:0] off_count_reg, off_count_next;
    logic [CNT_W-1:0]             prot_count_reg, prot_count_next;
    logic                         extra_ice_reg, extra_ice_next;
    logic [cima_pkg::MODE_W-1:0]  mode_reg, mode_next;

    // result register
    logic        out_valid_reg;
    logic [1:0]  make_mode_reg;
    logic        cool_demand_reg;
    logic        cold_go_reg;
    logic        ice_go_reg;

    logic        advance;
    logic        accept;

    logic                         saving;
    logic [cima_pkg::TEMP_W-1:0]  on_t;
    logic [cima_pkg::TEMP_W-1:0]  off_t;
    logic [cima_pkg::DELAY_W-1:0] delay;
    logic [CNT_W:0]               on_inc;
    logic [CNT_W:0]               prot_inc;
    logic [cima_pkg::DELAY_W-1:0] off_inc;
    logic                         full_gate;
    logic                         cgo, igo;

    // handshake
    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    assign out_valid   = out_valid_reg;
    assign make_mode   = make_mode_reg;
    assign cool_demand = cool_demand_reg;
    assign cold_go     = cold_go_reg;
    assign ice_go      = ice_go_reg;

    // apb port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        prdata = 32'd0;
        if (paddr[2] == cima_pkg::REG_PROTECT_TEMP)
        begin
            prdata = {22'd0, protect_temp_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            protect_temp_reg <= cima_pkg::PROTECT_TEMP_RESET;
        end
        else if (cfg_write && paddr[2] == cima_pkg::REG_PROTECT_TEMP)
        begin
            protect_temp_reg <= pwdata[9:0];
        end
    end

    // thresholds
    assign saving = sleep_reg || nouse_reg;

    always_comb
    begin
        if (weak_reg)
        begin
            on_t = cima_pkg::ON_WEAK;
        end
        else if (saving)
        begin
            on_t = cima_pkg::ON_SAVING;
        end
        else
        begin
            on_t = cima_pkg::ON_NORMAL;
        end

        if (weak_reg)
        begin
            off_t = cima_pkg::OFF_WEAK;
            delay = cima_pkg::DELAY_SHORT;
        end
        else if (amb_reg < cima_pkg::AMBIENT_WARM)
        begin
            off_t = saving ? cima_pkg::OFF_COOL_SAVING : cima_pkg::OFF_COOL_NORMAL;
            delay = cima_pkg::DELAY_SHORT;
        end
        else if (saving)
        begin
            off_t = cima_pkg::OFF_WARM_SAVING;
            delay = cima_pkg::DELAY_WARM_SAVING;
        end
        else
        begin
            off_t = cima_pkg::OFF_WARM_NORMAL;
            delay = cima_pkg::DELAY_WARM_NORMAL;
        end
    end

    assign on_inc   = {1'b0, on_count_reg} + 1'b1;
    assign prot_inc = {1'b0, prot_count_reg} + 1'b1;
    assign off_inc  = off_count_reg + 1'b1;

    // thermostat
    always_comb
    begin
        demand_next     = demand_reg;
        on_count_next   = on_count_reg;
        off_count_next  = off_count_reg;
        prot_count_next = prot_count_reg;

        if (temp_reg >= on_t)
        begin
            if (on_inc >= QMAX)
            begin
                on_count_next = QMAX[CNT_W-1:0];
                demand_next   = 1'b1;
            end
            else
            begin
                on_count_next = on_inc[CNT_W-1:0];
            end
            off_count_next = '0;
        end
        else
        begin
            on_count_next = '0;
            if (demand_reg && temp_reg <= off_t)
            begin
                if (off_inc >= delay)
                begin
                    off_count_next = '0;
                    demand_next    = 1'b0;
                end
                else
                begin
                    off_count_next = off_inc;
                end
            end
            else
            begin
                off_count_next = '0;
            end
        end

        // low-temperature protect
        if (temp_reg <= protect_temp_reg)
        begin
            if (prot_inc >= QMAX)
            begin
                prot_count_next = QMAX[CNT_W-1:0];
                demand_next     = 1'b0;
            end
            else
            begin
                prot_count_next = prot_inc[CNT_W-1:0];
            end
        end
        else
        begin
            prot_count_next = '0;
        end
    end

    // go conditions
    always_comb
    begin
        cgo = cf_reg[cima_pkg::COLD_EN] && cf_reg[cima_pkg::COLD_FILLED] && demand_next
              && !init_reg && !cf_reg[cima_pkg::COLD_FAULT];

        if (icf_reg[cima_pkg::ICE_FULL])
        begin
            full_gate      = extra_ice_reg;
            extra_ice_next = extra_ice_reg;
        end
        else
        begin
            full_gate      = 1'b1;
            extra_ice_next = icf_reg[cima_pkg::ICE_FIRST];
        end

        igo = icf_reg[cima_pkg::ICE_ON] && !icf_reg[cima_pkg::ICE_LOW] && full_gate
              && !sleep_reg && !init_reg && !icf_reg[cima_pkg::ICE_SAFETY]
              && !icf_reg[cima_pkg::ICE_FAULT] && !icf_reg[cima_pkg::ICE_SERVICE];
    end

    // make-mode arbiter
    always_comb
    begin
        mode_next = mode_reg;
        case (mode_reg)
            cima_pkg::MODE_STOP:
            begin
                if (cold_pri_reg)
                begin
                    mode_next = cgo ? cima_pkg::MODE_COLD
                              : (igo ? cima_pkg::MODE_ICE : cima_pkg::MODE_STOP);
                end
                else
                begin
                    mode_next = igo ? cima_pkg::MODE_ICE
                              : (cgo ? cima_pkg::MODE_COLD : cima_pkg::MODE_STOP);
                end
            end
            cima_pkg::MODE_COLD:
            begin
                if (!cgo || (!cold_pri_reg && igo))
                begin
                    mode_next = cima_pkg::MODE_STOP;
                end
            end
            cima_pkg::MODE_ICE:
            begin
                if (standby_reg && (!igo || (cold_pri_reg && cgo)))
                begin
                    mode_next = cima_pkg::MODE_STOP;
                end
            end
            default:
            begin
                mode_next = cima_pkg::MODE_STOP;
            end
        endcase
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            temp_reg     <= cold_temp;
            amb_reg      <= ambient_deg;
            weak_reg     <= cold_weak;
            sleep_reg    <= sleep_active;
            nouse_reg    <= no_use_saving;
            init_reg     <= ice_init_active;
            cf_reg       <= cold_flags;
            icf_reg      <= ice_flags;
            standby_reg  <= ice_standby;
            cold_pri_reg <= cold_first;
            enable_reg   <= decision_enable;
        end
    end

    // state update, once per evaluated tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            demand_reg     <= 1'b0;
            on_count_reg   <= '0;
            off_count_reg  <= '0;
            prot_count_reg <= '0;
            extra_ice_reg  <= 1'b0;
            mode_reg       <= cima_pkg::MODE_STOP;
        end
        else if (advance && enable_reg)
        begin
            demand_reg     <= demand_next;
            on_count_reg   <= on_count_next;
            off_count_reg  <= off_count_next;
            prot_count_reg <= prot_count_next;
            extra_ice_reg  <= extra_ice_next;
            mode_reg       <= mode_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (enable_reg)
            begin
                make_mode_reg   <= mode_next;
                cool_demand_reg <= demand_next;
                cold_go_reg     <= cgo;
                ice_go_reg      <= igo;
            end
            else
            begin
                make_mode_reg   <= mode_reg;
                cool_demand_reg <= demand_reg;
                cold_go_reg     <= 1'b0;
                ice_go_reg      <= 1'b0;
            end
        end
    end

endmodule
